// ----- rtl/gpp_pkg.sv -----
`default_nettype none
package gpp_pkg;

  // Store geometry
  localparam int MAX_POINTS     = 64;
  localparam int MAX_DIMS       = 8;
  localparam int EXP_TABLE_SIZE = 2048;
  localparam int PT_W           = $clog2(MAX_POINTS);
  localparam int DIM_W          = $clog2(MAX_DIMS);
  localparam int EXP_AW         = $clog2(EXP_TABLE_SIZE);

  // Arithmetic widths
  localparam int STEP_SHIFT = 10;   // exp table step of 1/64 in Q16.16
  localparam int EXP_W      = 17;   // table entries are at most 1.0 in Q16.16
  localparam int Q_W        = 52;   // squared distance accumulator
  localparam int ACC_W      = 56;   // dot product accumulators
  localparam int DIV_STEPS  = 48;   // 32 bit numerator shifted up by 16

  localparam logic [31:0]        EXP_RATIO = 32'd4261543595; // exp(-1/128) in Q32
  localparam logic [30:0]        EXP_SEED  = 31'h4000_0000;  // 1.0 in Q30
  localparam logic signed [31:0] S32_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN   = 32'sh8000_0000;

  typedef enum logic [2:0] {
    CMD_POINT  = 3'd0,
    CMD_ALPHA  = 3'd1,
    CMD_FACTOR = 3'd2,
    CMD_MEAN   = 3'd3,
    CMD_ISTD   = 3'd4,
    CMD_ILEN   = 3'd5,
    CMD_QUERY  = 3'd6,
    CMD_NOP    = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    REG_SIGVAR = 3'd0,
    REG_NPTS   = 3'd1,
    REG_NDIMS  = 3'd2,
    REG_TMEAN  = 3'd3,
    REG_TSTD   = 3'd4
  } reg_e;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE,
    ST_XS_A, ST_XS_B,
    ST_K_RD, ST_K_D1, ST_K_D2, ST_K_D3, ST_K_E, ST_K_F, ST_K_G, ST_K_H,
    ST_M_A, ST_M_B,
    ST_S_RD, ST_S_D, ST_S_ACC, ST_S_NUM, ST_S_DIV, ST_S_SQ, ST_S_VV,
    ST_V_A, ST_V_B, ST_DONE
  } state_e;

  // Divider handshake
  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'(S32_MAX)) r = S32_MAX;
    else if (x < 64'(S32_MIN)) r = S32_MIN;
    else r = x[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gaussian_process_predictor_unit.sv -----
`default_nettype none
// Gaussian process predictor with RBF kernel, signed Q16.16.
// Input stream: tuser carries the command, tdata the row, column and value,
// tlast marks the final query coordinate. Loads go straight into the stores.
// A query coordinate with tlast set starts a prediction; the result leaves on
// the output stream as one item.
// The kernel and solve loops share the single 32x32 multiplier, and the
// one-bit-a-cycle divider holds each row of the forward substitution until
// its quotient is done (a zero diagonal skips it).
// After reset the block fills the exponential table memory and holds
// s_axis_tready low; configuration writes are taken at any time. Loads are
// accepted while a result waits; a prediction that finishes while the previous
// result is still stalled holds until the receiver takes it.
// Configuration is written by cfg_we_i with a register index and data.
module gaussian_process_predictor_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // row_index[5:0], col_index[11:6], value[43:12], pad
  input  wire logic [2:0]  s_axis_tuser,  // cmd[2:0]
  input  wire logic        s_axis_tlast,
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata   // pred_mean[31:0], pred_variance[62:32],
                                          // variance_clamped[63]
);

  localparam int PT_W   = gpp_pkg::PT_W;
  localparam int DIM_W  = gpp_pkg::DIM_W;
  localparam int EXP_AW = gpp_pkg::EXP_AW;
  localparam int Q_W    = gpp_pkg::Q_W;
  localparam int ACC_W  = gpp_pkg::ACC_W;
  localparam int EXP_W  = gpp_pkg::EXP_W;
  localparam int STEP_SHIFT_LO = gpp_pkg::STEP_SHIFT;

  gpp_pkg::state_e state_q, state_d;

  // Configuration
  logic [30:0]        sigvar_q;
  logic [6:0]         npts_q;
  logic [3:0]         ndims_q;
  logic signed [31:0] tmean_q;
  logic [30:0]        tstd_q;

  // Loop control
  logic [EXP_AW:0]    init_q, init_d;
  logic [30:0]        e_q, e_d;
  logic [PT_W:0]      i_q, i_d, j_q, j_d;
  logic [DIM_W:0]     k_q, k_d;
  logic               ovalid_q, ovalid_d;

  // Datapath
  logic signed [31:0]     mul_a_q, mul_a_d, mul_b_q, mul_b_d;
  logic signed [Q_W-1:0]  qd_q, qd_d;
  logic signed [ACC_W-1:0] acc_q, acc_d, acc2_q, acc2_d;
  logic signed [31:0]     df_w;
  logic signed [31:0]     pm_q, pm_d, r_q, r_d;
  logic [30:0]            var_q, var_d;
  logic                   clamp_q, clamp_d;
  logic signed [31:0]     om_q, om_d;
  logic [30:0]            ov_q, ov_d;
  logic                   oc_q, oc_d;

  logic signed [31:0] dmean_q [gpp_pkg::MAX_DIMS];
  logic signed [31:0] dstd_q  [gpp_pkg::MAX_DIMS];
  logic signed [31:0] dlen_q  [gpp_pkg::MAX_DIMS];
  logic signed [31:0] qc_q    [gpp_pkg::MAX_DIMS];
  logic signed [31:0] xs_q    [gpp_pkg::MAX_DIMS];

  // Request decode
  logic               in_req;
  gpp_pkg::cmd_e      cmd_w;
  logic [PT_W-1:0]    row_w;
  logic [5:0]         col_w;
  logic signed [31:0] val_w;
  logic               col_ok;

  assign in_req = s_axis_tvalid & s_axis_tready;
  assign cmd_w  = gpp_pkg::cmd_e'(s_axis_tuser);
  assign row_w  = s_axis_tdata[PT_W-1:0];
  assign col_w  = s_axis_tdata[11:6];
  assign val_w  = signed'(s_axis_tdata[43:12]);
  assign col_ok = (col_w < 6'(gpp_pkg::MAX_DIMS));

  // Effective counts
  logic [PT_W:0]  n_w;
  logic [DIM_W:0] d_w;
  assign n_w = (npts_q == 7'd0) ? (PT_W+1)'(1) :
               (npts_q > 7'(gpp_pkg::MAX_POINTS)) ? (PT_W+1)'(gpp_pkg::MAX_POINTS) :
               (PT_W+1)'(npts_q);
  assign d_w = (ndims_q == 4'd0) ? (DIM_W+1)'(1) :
               (ndims_q > 4'(gpp_pkg::MAX_DIMS)) ? (DIM_W+1)'(gpp_pkg::MAX_DIMS) :
               (DIM_W+1)'(ndims_q);

  logic [DIM_W-1:0] kx;
  logic [PT_W-1:0]  ix, jx;
  assign kx = k_q[DIM_W-1:0];
  assign ix = i_q[PT_W-1:0];
  assign jx = j_q[PT_W-1:0];

  // Shared multiplier, product floor-shifted by 16
  logic signed [63:0] prod_w;
  logic signed [47:0] mq_w;
  assign prod_w = mul_a_q * mul_b_q;
  assign mq_w   = prod_w[63:16];

  // Exp table recurrence
  logic [63:0] e_prod;
  assign e_prod = 64'(e_q) * 64'(gpp_pkg::EXP_RATIO) + 64'(33'h0_8000_0000);

  // Memories
  logic               tc_we, w_we, l_we, kv_we, sv_we, ex_we;
  logic [31:0]        tc_rd, w_rd, l_rd, kv_rd, sv_rd;
  logic [EXP_W-1:0]   ex_rd, ex_wd;

  assign tc_we = in_req && (cmd_w == gpp_pkg::CMD_POINT) && col_ok;
  assign w_we  = in_req && (cmd_w == gpp_pkg::CMD_ALPHA);
  assign l_we  = in_req && (cmd_w == gpp_pkg::CMD_FACTOR) && (col_w <= 6'(row_w));
  assign kv_we = (state_q == gpp_pkg::ST_K_G);
  assign sv_we = (state_q == gpp_pkg::ST_S_SQ);
  assign ex_we = (state_q == gpp_pkg::ST_INIT);
  assign ex_wd = EXP_W'((32'(e_q) + 32'd8192) >> 14);

  gpp_ram #(.WIDTH(32), .DEPTH(gpp_pkg::MAX_POINTS * gpp_pkg::MAX_DIMS)) u_tc (
    .clk_i, .we_i(tc_we), .waddr_i({row_w, col_w[DIM_W-1:0]}), .wdata_i(val_w),
    .raddr_i({ix, kx}), .rdata_o(tc_rd));

  gpp_ram #(.WIDTH(32), .DEPTH(gpp_pkg::MAX_POINTS)) u_w (
    .clk_i, .we_i(w_we), .waddr_i(row_w), .wdata_i(val_w),
    .raddr_i(ix), .rdata_o(w_rd));

  gpp_ram #(.WIDTH(32), .DEPTH(gpp_pkg::MAX_POINTS * gpp_pkg::MAX_POINTS)) u_l (
    .clk_i, .we_i(l_we), .waddr_i({row_w, col_w[PT_W-1:0]}), .wdata_i(val_w),
    .raddr_i({ix, jx}), .rdata_o(l_rd));

  gpp_ram #(.WIDTH(32), .DEPTH(gpp_pkg::MAX_POINTS)) u_kv (
    .clk_i, .we_i(kv_we), .waddr_i(ix), .wdata_i(gpp_pkg::sat32(64'(mq_w))),
    .raddr_i(ix), .rdata_o(kv_rd));

  gpp_ram #(.WIDTH(32), .DEPTH(gpp_pkg::MAX_POINTS)) u_sv (
    .clk_i, .we_i(sv_we), .waddr_i(ix), .wdata_i(r_q),
    .raddr_i(jx), .rdata_o(sv_rd));

  gpp_ram #(.WIDTH(EXP_W), .DEPTH(gpp_pkg::EXP_TABLE_SIZE)) u_ex (
    .clk_i, .we_i(ex_we), .waddr_i(init_q[EXP_AW-1:0]), .wdata_i(ex_wd),
    .raddr_i(qd_q[STEP_SHIFT_LO +: EXP_AW]), .rdata_o(ex_rd));

  logic ex_zero;
  assign ex_zero = (qd_q[Q_W-1:STEP_SHIFT_LO] >= (Q_W-STEP_SHIFT_LO)'(gpp_pkg::EXP_TABLE_SIZE));

  // Divider
  gpp_pkg::div_ctl_t  div_ctl;
  logic signed [31:0] num_w, div_q;
  assign num_w = gpp_pkg::sat32(64'(signed'(kv_rd)) - 64'(acc_q));
  assign div_ctl.start = (state_q == gpp_pkg::ST_S_NUM) && (l_rd != 32'd0);

  gpp_div u_div (
    .clk_i, .rst_ni, .start_i(div_ctl.start), .num_i(num_w), .den_i(signed'(l_rd)),
    .done_o(div_ctl.done), .quo_o(div_q));

  logic k_last, i_last;
  assign k_last = ((k_q + (DIM_W+1)'(1)) == d_w);
  assign i_last = ((i_q + (PT_W+1)'(1)) == n_w);

  logic signed [ACC_W-1:0] varw;
  assign varw = ACC_W'(signed'({1'b0, sigvar_q})) - acc2_q;
  assign df_w = gpp_pkg::sat32(64'(mq_w));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gpp_pkg::ST_INIT:
        if (init_q == (EXP_AW+1)'(gpp_pkg::EXP_TABLE_SIZE - 1)) state_d = gpp_pkg::ST_IDLE;
      gpp_pkg::ST_IDLE:
        if (in_req && (cmd_w == gpp_pkg::CMD_QUERY) && s_axis_tlast) state_d = gpp_pkg::ST_XS_A;
      gpp_pkg::ST_XS_A:  state_d = gpp_pkg::ST_XS_B;
      gpp_pkg::ST_XS_B:  state_d = k_last ? gpp_pkg::ST_K_RD : gpp_pkg::ST_XS_A;
      gpp_pkg::ST_K_RD:  state_d = gpp_pkg::ST_K_D1;
      gpp_pkg::ST_K_D1:  state_d = gpp_pkg::ST_K_D2;
      gpp_pkg::ST_K_D2:  state_d = gpp_pkg::ST_K_D3;
      gpp_pkg::ST_K_D3:  state_d = k_last ? gpp_pkg::ST_K_E : gpp_pkg::ST_K_RD;
      gpp_pkg::ST_K_E:   state_d = gpp_pkg::ST_K_F;
      gpp_pkg::ST_K_F:   state_d = gpp_pkg::ST_K_G;
      gpp_pkg::ST_K_G:   state_d = gpp_pkg::ST_K_H;
      gpp_pkg::ST_K_H:   state_d = i_last ? gpp_pkg::ST_M_A : gpp_pkg::ST_K_RD;
      gpp_pkg::ST_M_A:   state_d = gpp_pkg::ST_M_B;
      gpp_pkg::ST_M_B:   state_d = gpp_pkg::ST_S_RD;
      gpp_pkg::ST_S_RD:  state_d = (j_q == i_q) ? gpp_pkg::ST_S_NUM : gpp_pkg::ST_S_D;
      gpp_pkg::ST_S_D:   state_d = gpp_pkg::ST_S_ACC;
      gpp_pkg::ST_S_ACC: state_d = gpp_pkg::ST_S_RD;
      gpp_pkg::ST_S_NUM: state_d = (l_rd == 32'd0) ? gpp_pkg::ST_S_SQ : gpp_pkg::ST_S_DIV;
      gpp_pkg::ST_S_DIV: if (div_ctl.done) state_d = gpp_pkg::ST_S_SQ;
      gpp_pkg::ST_S_SQ:  state_d = gpp_pkg::ST_S_VV;
      gpp_pkg::ST_S_VV:  state_d = i_last ? gpp_pkg::ST_V_A : gpp_pkg::ST_S_RD;
      gpp_pkg::ST_V_A:   state_d = gpp_pkg::ST_V_B;
      gpp_pkg::ST_V_B:   state_d = gpp_pkg::ST_DONE;
      gpp_pkg::ST_DONE:  if (!ovalid_q || m_axis_tready) state_d = gpp_pkg::ST_IDLE;
      default:           state_d = gpp_pkg::ST_IDLE;
    endcase
  end

  // Datapath and counters
  always_comb begin
    init_d   = init_q;
    e_d      = e_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    mul_a_d  = mul_a_q;
    mul_b_d  = mul_b_q;
    qd_d     = qd_q;
    acc_d    = acc_q;
    acc2_d   = acc2_q;
    pm_d     = pm_q;
    r_d      = r_q;
    var_d    = var_q;
    clamp_d  = clamp_q;
    om_d     = om_q;
    ov_d     = ov_q;
    oc_d     = oc_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    unique case (state_q)
      gpp_pkg::ST_INIT: begin
        init_d = init_q + (EXP_AW+1)'(1);
        e_d    = 31'(e_prod >> 32);
      end
      gpp_pkg::ST_IDLE: begin
        k_d   = '0;
        i_d   = '0;
        acc_d = '0;
        qd_d  = '0;
      end
      gpp_pkg::ST_XS_A: begin
        mul_a_d = gpp_pkg::sat32(64'(qc_q[kx]) - 64'(dmean_q[kx]));
        mul_b_d = dstd_q[kx];
      end
      gpp_pkg::ST_XS_B: begin
        k_d = k_last ? '0 : k_q + (DIM_W+1)'(1);
      end
      gpp_pkg::ST_K_D1: begin
        mul_a_d = gpp_pkg::sat32(64'(xs_q[kx]) - 64'(signed'(tc_rd)));
        mul_b_d = dlen_q[kx];
      end
      gpp_pkg::ST_K_D2: begin
        mul_a_d = df_w;
        mul_b_d = df_w;
      end
      gpp_pkg::ST_K_D3: begin
        qd_d = qd_q + Q_W'(mq_w);
        k_d  = k_last ? '0 : k_q + (DIM_W+1)'(1);
      end
      gpp_pkg::ST_K_F: begin
        mul_a_d = signed'({1'b0, sigvar_q});
        mul_b_d = ex_zero ? 32'sd0 : signed'(32'(ex_rd));
      end
      gpp_pkg::ST_K_G: begin
        mul_a_d = gpp_pkg::sat32(64'(mq_w));
        mul_b_d = signed'(w_rd);
      end
      gpp_pkg::ST_K_H: begin
        acc_d = acc_q + ACC_W'(mq_w);
        qd_d  = '0;
        i_d   = i_last ? '0 : i_q + (PT_W+1)'(1);
      end
      gpp_pkg::ST_M_A: begin
        mul_a_d = signed'({1'b0, tstd_q});
        mul_b_d = gpp_pkg::sat32(64'(acc_q));
      end
      gpp_pkg::ST_M_B: begin
        pm_d   = gpp_pkg::sat32(64'(tmean_q) + 64'(mq_w));
        acc_d  = '0;
        acc2_d = '0;
        i_d    = '0;
        j_d    = '0;
      end
      gpp_pkg::ST_S_D: begin
        mul_a_d = signed'(l_rd);
        mul_b_d = signed'(sv_rd);
      end
      gpp_pkg::ST_S_ACC: begin
        acc_d = acc_q + ACC_W'(mq_w);
        j_d   = j_q + (PT_W+1)'(1);
      end
      gpp_pkg::ST_S_NUM: begin
        // zero diagonal gives the saturated sign of the numerator
        if (num_w > 32'sd0) r_d = gpp_pkg::S32_MAX;
        else if (num_w < 32'sd0) r_d = gpp_pkg::S32_MIN;
        else r_d = 32'sd0;
      end
      gpp_pkg::ST_S_DIV: begin
        if (div_ctl.done) r_d = div_q;
      end
      gpp_pkg::ST_S_SQ: begin
        mul_a_d = r_q;
        mul_b_d = r_q;
      end
      gpp_pkg::ST_S_VV: begin
        acc2_d = acc2_q + ACC_W'(mq_w);
        acc_d  = '0;
        j_d    = '0;
        i_d    = i_last ? '0 : i_q + (PT_W+1)'(1);
      end
      gpp_pkg::ST_V_A: begin
        if (varw < 0) begin
          var_d   = '0;
          clamp_d = 1'b1;
        end else begin
          var_d   = varw[30:0];
          clamp_d = 1'b0;
        end
        mul_a_d = signed'({1'b0, tstd_q});
        mul_b_d = signed'({1'b0, tstd_q});
      end
      gpp_pkg::ST_V_B: begin
        mul_a_d = gpp_pkg::sat32(64'(mq_w));
        mul_b_d = signed'({1'b0, var_q});
      end
      gpp_pkg::ST_DONE: begin
        if (!ovalid_q || m_axis_tready) begin
          om_d     = pm_q;
          ov_d     = df_w[30:0];
          oc_d     = clamp_q;
          ovalid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == gpp_pkg::ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {oc_q, ov_q, om_q};

  // Control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gpp_pkg::ST_INIT;
      init_q   <= '0;
      e_q      <= gpp_pkg::EXP_SEED;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      ovalid_q <= 1'b0;
      sigvar_q <= 31'h0001_0000;
      npts_q   <= 7'd1;
      ndims_q  <= 4'd1;
      tmean_q  <= 32'sd0;
      tstd_q   <= 31'h0001_0000;
    end else begin
      state_q  <= state_d;
      init_q   <= init_d;
      e_q      <= e_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          gpp_pkg::REG_SIGVAR: sigvar_q <= cfg_wdata_i[30:0];
          gpp_pkg::REG_NPTS:   npts_q   <= cfg_wdata_i[6:0];
          gpp_pkg::REG_NDIMS:  ndims_q  <= cfg_wdata_i[3:0];
          gpp_pkg::REG_TMEAN:  tmean_q  <= signed'(cfg_wdata_i);
          gpp_pkg::REG_TSTD:   tstd_q   <= cfg_wdata_i[30:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mul_a_q <= mul_a_d;
    mul_b_q <= mul_b_d;
    qd_q    <= qd_d;
    acc_q   <= acc_d;
    acc2_q  <= acc2_d;
    pm_q    <= pm_d;
    r_q     <= r_d;
    var_q   <= var_d;
    clamp_q <= clamp_d;
    om_q    <= om_d;
    ov_q    <= ov_d;
    oc_q    <= oc_d;
    if (state_q == gpp_pkg::ST_XS_B) begin
      xs_q[kx] <= df_w;
    end
    if (in_req && col_ok) begin
      case (cmd_w)
        gpp_pkg::CMD_MEAN:  dmean_q[col_w[DIM_W-1:0]] <= val_w;
        gpp_pkg::CMD_ISTD:  dstd_q[col_w[DIM_W-1:0]]  <= val_w;
        gpp_pkg::CMD_ILEN:  dlen_q[col_w[DIM_W-1:0]]  <= val_w;
        gpp_pkg::CMD_QUERY: qc_q[col_w[DIM_W-1:0]]    <= val_w;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/gpp_ram.sv -----
`default_nettype none
module gpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/gpp_div.sv -----
`default_nettype none
module gpp_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic signed [31:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      quo_o
);

  localparam int QW = gpp_pkg::DIV_STEPS;
  localparam int CW = $clog2(QW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [31:0]   den_q, den_d;
  logic          neg_q, neg_d;

  logic [32:0]   rem_t;
  logic [31:0]   num_mag, den_mag;

  assign num_mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign den_mag = den_i[31] ? 32'(-den_i) : 32'(den_i);
  assign rem_t   = {rem_q, quo_q[QW-1]};

  // Restoring division on magnitudes, one quotient bit a cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = {num_mag, 16'h0000};
      den_d  = den_mag;
      neg_d  = num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      if (rem_t >= {1'b0, den_q}) begin
        rem_d = 32'(rem_t - {1'b0, den_q});
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = rem_t[31:0];
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // Sign and saturation of the truncated quotient
  always_comb begin
    if (neg_q) begin
      if (quo_q > QW'(33'h1_0000_0000 >> 1)) quo_o = gpp_pkg::S32_MIN;
      else quo_o = 32'(-signed'({1'b0, quo_q}));
    end else begin
      if (quo_q > QW'(gpp_pkg::S32_MAX)) quo_o = gpp_pkg::S32_MAX;
      else quo_o = signed'(quo_q[31:0]);
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

// ----- test/gpp_checker.sv -----
`timescale 1ns / 100ps
module gpp_checker
  import gpp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [47:0] s_data_i,
  input  logic [2:0]  s_user_i,
  input  logic        s_last_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [63:0] m_data_i,
  output int          fails_o,
  output int          pending_o,
  output int          results_o
);

  // field order matches the output word, highest bits first
  typedef struct packed {
    logic               clamped;
    logic [30:0]        variance;
    logic signed [31:0] mean;
  } prediction_t;

  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam int     EXP_DEPTH = 1024;

  // predictor copy of the block's registers and stores
  longint sig_var, n_pts, n_dims, t_mean, t_std;
  int     pt_coord [MAX_POINTS*MAX_DIMS];
  int     alpha    [MAX_POINTS];
  int     lfac     [MAX_POINTS*MAX_POINTS];
  int     dmean    [MAX_DIMS];
  int     distd    [MAX_DIMS];
  int     dilen    [MAX_DIMS];
  int     qcoord   [MAX_DIMS];
  longint exp_lut  [EXP_TABLE_SIZE];

  // expected results in order, ring of written and consumed counts
  prediction_t expected_mem [EXP_DEPTH];
  int          wr_cnt, rd_cnt;

  // Q30 recurrence, rounded to nearest Q16.16
  initial begin
    longint unsigned e;
    e = 64'd1 << 30;
    for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
      exp_lut[i] = longint'((e + 64'd8192) >> 14);
      e = (e * 64'd4261543595 + (64'd1 << 31)) >> 32;
    end
  end

  function automatic longint clip32(longint x);
    if (x > SMAX) return SMAX;
    if (x < SMIN) return SMIN;
    return x;
  endfunction

  // Q16.16 product, floor division by 2^16
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint limit_count(longint c, longint maxv);
    if (c < 1) return 1;
    if (c > maxv) return maxv;
    return c;
  endfunction

  function automatic prediction_t predict_gp();
    prediction_t r;
    longint xs [MAX_DIMS];
    longint kv [MAX_POINTS];
    longint vv [MAX_POINTS];
    longint acc, q, df, num, dv, s2, vr;
    longint unsigned idx;
    int n, d;
    n = int'(limit_count(n_pts, MAX_POINTS));
    d = int'(limit_count(n_dims, MAX_DIMS));
    r.clamped = 1'b0;
    for (int k = 0; k < d; k++)
      xs[k] = clip32(qmul(clip32(longint'(qcoord[k]) - dmean[k]), distd[k]));
    // kernel vector
    for (int i = 0; i < n; i++) begin
      q = 0;
      for (int k = 0; k < d; k++) begin
        df = clip32(qmul(clip32(xs[k] - pt_coord[i*MAX_DIMS+k]), dilen[k]));
        q += qmul(df, df);
      end
      idx = longint'(q) >> STEP_SHIFT;
      kv[i] = clip32(qmul(sig_var, (idx < EXP_TABLE_SIZE) ? exp_lut[idx] : 0));
    end
    acc = 0;
    for (int i = 0; i < n; i++) acc += qmul(kv[i], alpha[i]);
    r.mean = 32'(clip32(t_mean + qmul(t_std, clip32(acc))));
    // forward substitution
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int j = 0; j < i; j++) acc += qmul(lfac[i*MAX_POINTS+j], vv[j]);
      num = clip32(kv[i] - acc);
      dv = lfac[i*MAX_POINTS+i];
      if (dv == 0) vv[i] = (num > 0) ? SMAX : ((num < 0) ? SMIN : 0);
      else vv[i] = clip32((num * 65536) / dv);
    end
    acc = 0;
    for (int i = 0; i < n; i++) acc += qmul(vv[i], vv[i]);
    vr = sig_var - acc;
    if (vr < 0) begin
      vr = 0;
      r.clamped = 1'b1;
    end
    vr = clip32(vr);
    s2 = clip32(qmul(t_std, t_std));
    r.variance = 31'(clip32(qmul(s2, vr)));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    prediction_t got, want;
    cmd_e        cmd;
    logic [5:0]  row, col;
    int          val;
    if (!rst_ni) begin
      sig_var = 65536;
      n_pts = 1;
      n_dims = 1;
      t_mean = 0;
      t_std = 65536;
      fails_o = 0;
      results_o = 0;
      wr_cnt = 0;
      rd_cnt = 0;
    end else begin
      // results first: a request taken on this edge cannot have one yet
      if (m_valid_i && m_ready_i) begin
        got = m_data_i;
        results_o++;
        if (wr_cnt == rd_cnt) begin
          fails_o++;
          if (fails_o <= 10) $display("unexpected result %h", m_data_i);
        end else begin
          want = expected_mem[rd_cnt % EXP_DEPTH];
          rd_cnt++;
          if (got != want) begin
            fails_o++;
            if (fails_o <= 10)
              $display("mismatch: mean exp %h got %h, var exp %h got %h, clamp exp %b got %b",
                       want.mean, got.mean, want.variance, got.variance,
                       want.clamped, got.clamped);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SIGVAR: sig_var = longint'(cfg_wdata_i[30:0]);
          REG_NPTS:   n_pts = longint'(cfg_wdata_i[6:0]);
          REG_NDIMS:  n_dims = longint'(cfg_wdata_i[3:0]);
          REG_TMEAN:  t_mean = longint'($signed(cfg_wdata_i));
          REG_TSTD:   t_std = longint'(cfg_wdata_i[30:0]);
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        cmd = cmd_e'(s_user_i);
        row = s_data_i[5:0];
        col = s_data_i[11:6];
        val = $signed(s_data_i[43:12]);
        case (cmd)
          CMD_POINT:  if (col < MAX_DIMS) pt_coord[row*MAX_DIMS+col] = val;
          CMD_ALPHA:  alpha[row] = val;
          CMD_FACTOR: if (col <= row) lfac[row*MAX_POINTS+col] = val;
          CMD_MEAN:   if (col < MAX_DIMS) dmean[col] = val;
          CMD_ISTD:   if (col < MAX_DIMS) distd[col] = val;
          CMD_ILEN:   if (col < MAX_DIMS) dilen[col] = val;
          CMD_QUERY: begin
            if (col < MAX_DIMS) qcoord[col] = val;
            if (s_last_i) begin
              expected_mem[wr_cnt % EXP_DEPTH] = predict_gp();
              wr_cnt++;
            end
          end
          default: ;
        endcase
      end
    end
    pending_o = wr_cnt - rd_cnt;
  end

endmodule

// ----- test/tb_gaussian_process_predictor_unit.sv -----
`timescale 1ns / 100ps
module tb_gaussian_process_predictor_unit;
  import gpp_pkg::*;

  localparam int STALL_LIMIT = 80000;
  localparam int FILL_POINTS = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // row_index, col_index, value, pad
  logic [2:0]  s_axis_tuser = '0;  // cmd
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;       // pred_mean, pred_variance, variance_clamped

  int fails, pending, results, stall_cnt, queries_sent;
  bit jitter_on = 1'b1;

  always #5 clk_i = ~clk_i;

  gaussian_process_predictor_unit u_top (.*);

  gpp_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .s_user_i(s_axis_tuser), .s_last_i(s_axis_tlast),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .fails_o(fails), .pending_o(pending), .results_o(results)
  );

  // receiver backpressure
  always @(negedge clk_i)
    m_axis_tready <= !jitter_on || ($urandom_range(99) >= 9);

  // watchdog on cycles with no transfer at all
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog expired");
      $display("tb_gaussian_process_predictor_unit NOT OK");
      $finish;
    end
  end

  function automatic int spread(int half_range);
    return int'($urandom_range(0, 2 * half_range)) - half_range;
  endfunction

  task automatic send(cmd_e cmd, int row, int col, int val, bit last);
    if (jitter_on)
      while ($urandom_range(99) < 9) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, val[31:0], col[5:0], row[5:0]};
    s_axis_tlast  <= last;
    if (cmd == CMD_QUERY && last) queries_sent++;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // one write, with the write enable dropped again before the next
  task automatic write_reg(reg_e idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_config(int sv, int np, int nd, int tm, int ts);
    drain();
    write_reg(REG_SIGVAR, sv);
    write_reg(REG_NPTS, np);
    write_reg(REG_NDIMS, nd);
    write_reg(REG_TMEAN, tm);
    write_reg(REG_TSTD, ts);
  endtask

  // one query: all active coordinates, last on the final one
  task automatic run_query(int nd, bit wide);
    for (int k = 0; k < nd; k++)
      send(CMD_QUERY, $urandom_range(63), k,
           wide ? int'($urandom) : spread(131072), k == nd - 1);
  endtask

  // arbitrary request, fields anywhere in their range
  task automatic noise_item();
    int val;
    val = ($urandom_range(3) == 0) ? int'($urandom) : spread(131072);
    send(cmd_e'($urandom_range(7)), $urandom_range(63), $urandom_range(63), val,
         $urandom_range(1));
  endtask

  task automatic random_phase(int nd, int count, bit full_nd);
    int done_cnt;
    done_cnt = 0;
    while (done_cnt < count) begin
      if ($urandom_range(99) < 70) begin
        run_query(full_nd ? 8 : nd, $urandom_range(9) == 0);
        done_cnt += nd;
      end else begin
        noise_item();
        done_cnt++;
      end
    end
  endtask

  initial begin
    int nd;
    stall_cnt = 0;
    queries_sent = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill the stores of the points in use with well-conditioned data
    for (int i = 0; i < FILL_POINTS; i++) begin
      for (int k = 0; k < MAX_DIMS; k++) send(CMD_POINT, i, k, spread(131072), 1'b0);
      send(CMD_ALPHA, i, 0, spread(65536), 1'b0);
      for (int j = 0; j < i; j++) send(CMD_FACTOR, i, j, spread(16384), 1'b0);
      send(CMD_FACTOR, i, i, $urandom_range(32768, 131072), 1'b0);
    end
    for (int k = 0; k < MAX_DIMS; k++) begin
      send(CMD_MEAN, 0, k, spread(65536), 1'b0);
      send(CMD_ISTD, 0, k, $urandom_range(32768, 98304), 1'b0);
      send(CMD_ILEN, 0, k, $urandom_range(16384, 65536), 1'b0);
      send(CMD_QUERY, 0, k, spread(131072), 1'b0);
    end

    // directed: reset configuration, one point, one dimension
    send(CMD_QUERY, 0, 0, 32'h7FFF_FFFF, 1'b1);
    send(CMD_QUERY, 0, 0, 32'h8000_0000, 1'b1);
    send(CMD_QUERY, 63, 0, 0, 1'b1);
    send(CMD_QUERY, 0, 9, 12345, 1'b1);       // ignored column, still predicts
    send(CMD_NOP, 5, 5, -1, 1'b1);            // unused command
    send(CMD_POINT, 63, 63, -1, 1'b0);        // column out of range
    send(CMD_FACTOR, 2, 5, -1, 1'b0);         // above the diagonal
    send(CMD_ALPHA, 0, 0, 32'h7FFF_FFFF, 1'b1);
    send(CMD_QUERY, 0, 0, 4096, 1'b1);
    send(CMD_ALPHA, 0, 0, 32'h8000_0000, 1'b0);
    send(CMD_QUERY, 0, 0, -4096, 1'b1);
    send(CMD_FACTOR, 0, 0, 0, 1'b0);          // zero diagonal
    send(CMD_QUERY, 0, 0, 0, 1'b1);
    send(CMD_FACTOR, 0, 0, 256, 1'b0);        // tiny diagonal clamps variance
    send(CMD_QUERY, 0, 0, 0, 1'b1);
    send(CMD_FACTOR, 0, 0, 65536, 1'b0);
    send(CMD_ALPHA, 0, 0, 65536, 1'b0);
    send(CMD_QUERY, 0, 0, 70000, 1'b1);

    // extremes of every register
    set_config(32'h7FFF_FFFF, FILL_POINTS, 8, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_query(8, 1'b0);
    run_query(8, 1'b1);
    set_config(0, 0, 0, 32'h8000_0000, 0);
    run_query(1, 1'b0);
    send(CMD_QUERY, 0, 0, 32'h7FFF_FFFF, 1'b1);
    set_config(65536, FILL_POINTS, 15, 0, 65536);
    run_query(8, 1'b0);
    drain();
    write_reg(reg_e'(5), 32'hFFFF_FFFF);
    write_reg(reg_e'(7), 32'h0);

    // random phases, mostly small problems
    for (int p = 0; p < 6; p++) begin
      nd = $urandom_range(1, 8);
      set_config($urandom_range(16384, 131072), $urandom_range(1, FILL_POINTS), nd,
                 spread(1 << 20), $urandom_range(16384, 262144));
      jitter_on = (p != 3);
      random_phase(nd, 15, 1'b0);
    end
    jitter_on = 1'b1;

    drain();
    repeat (100) @(negedge clk_i);
    $display("covered store loads, ignored and unused requests, %0d predictions over",
             queries_sent);
    $display("register extremes and six random settings; %0d results checked", results);
    if (fails == 0 && pending == 0)
      $display("tb_gaussian_process_predictor_unit OK");
    else
      $display("tb_gaussian_process_predictor_unit NOT OK");
    $finish;
  end

endmodule
